// File: hdl/fcce_pkg.sv
// Package for the FAT cluster chain engine: commands, status codes, states.
// No dependencies.
`timescale 1ns / 1ps
package fcce_pkg;

  localparam logic [27:0] EndMark = 28'hFFFFFFF;
  localparam logic [27:0] EndMin  = 28'hFFFFFF8;

  typedef enum logic [2:0] {
    CMD_LOAD     = 3'd0,
    CMD_READ     = 3'd1,
    CMD_ALLOC    = 3'd2,
    CMD_LOC_RD   = 3'd3,
    CMD_LOC_WR   = 3'd4,
    CMD_TRUNC    = 3'd5,
    CMD_LENGTH   = 3'd6,
    CMD_UNUSED   = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ENDED = 2'd1,
    ST_NOFREE = 2'd2
  } status_e;

  localparam logic [1:0] CfgShift = 2'd0;
  localparam logic [1:0] CfgLba   = 2'd1;
  localparam logic [1:0] CfgCount = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,       // issue read of cur
    S_RDW,      // wait for read data
    S_ACT,      // act on read data
    S_SCAN_RD,  // free scan read
    S_SCAN_W,
    S_SCAN_ACT,
    S_FREE_RD,  // truncate tail freeing
    S_FREE_W,
    S_FREE_ACT,
    S_SECT,     // sector arithmetic
    S_OUT
  } state_e;

endpackage

// File: hdl/fcce_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module fcce_ram #(
  parameter int Width = 28,
  parameter int Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: hdl/fat_cluster_chain_engine_unit.sv
// FAT cluster chain engine top level: sequencer around one table RAM.
// Depends on fcce_pkg and fcce_ram.
`timescale 1ns / 1ps
// One command per beat; s_axis_tready is low while a command runs and while
// its result waits in the output register. Every table access uses the single
// RAM port in turn: address, registered read, decide. Locate and length read
// one table entry per cluster walked, and truncate also reads and clears each
// freed cluster. Free scans restart at entry 2, so each allocation reads
// entries from 2 upward until it finds a free one, and each chain extension
// in locate write adds a link write. A low m_axis_tready holds the engine
// until the result beat is taken.
module fat_cluster_chain_engine_unit
  import fcce_pkg::*;
#(
  parameter int TABLE_ENTRIES = 65536
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [1:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[2:0], start_cluster[18:3], byte_offset[50:19], entry_value[78:51]
  input  logic [79:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cluster[27:0], sector_lba[67:28], chain_length[84:68], status[86:85]
  output logic [87:0]  m_axis_tdata
);
  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] Entries = LW'(TABLE_ENTRIES);

  state_e state_q, state_d;
  logic [4:0]  shift_q;
  logic [31:0] lba_q;
  logic [16:0] count_q;

  cmd_e        cmd_q, cmd_d;
  logic [27:0] cur_q, cur_d;
  logic [27:0] nxt_q, nxt_d;
  logic [31:0] n_q, n_d;
  logic [31:0] rem_q, rem_d;
  logic [16:0] len_q, len_d;
  logic [1:0]  st_q, st_d;
  logic [27:0] resc_q, resc_d;
  logic        sect_q, sect_d;
  logic        ext_q, ext_d;     // scan serves a chain extension; also marks the clear step of truncate freeing
  logic [27:0] scan_q, scan_d;
  logic [39:0] sec_q, sec_d;
  logic        ov_q, ov_d;
  logic [87:0] od_q, od_d;

  logic          we;
  logic [AW-1:0] addr;
  logic [27:0]   wdata, rdata;

  fcce_ram #(.Width(28), .Depth(TABLE_ENTRIES)) u_ram (
    .clk_i(clk_i), .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );

  logic [LW-1:0] lim;
  logic [4:0]    sh;
  logic [2:0]    cmd_in;
  logic [15:0]   start_in;
  logic [31:0]   off_in;
  logic [27:0]   val_in;
  logic [31:0]   n_in, rem_in;

  assign lim = ({15'd0, count_q} > 32'(Entries)) ? Entries : LW'(count_q);
  assign sh  = (shift_q < 5'd9) ? 5'd9 : (shift_q > 5'd16) ? 5'd16 : shift_q;
  assign cmd_in   = s_axis_tdata[2:0];
  assign start_in = s_axis_tdata[18:3];
  assign off_in   = s_axis_tdata[50:19];
  assign val_in   = s_axis_tdata[78:51];
  assign n_in     = off_in >> sh;
  assign rem_in   = off_in & ((32'd1 << sh) - 32'd1);

  function automatic logic usable(logic [27:0] c, logic [LW-1:0] l);
    return (c >= 28'd2) && ({4'd0, c} < 32'(l));
  endfunction

  function automatic logic in_tab(logic [27:0] c);
    return {4'd0, c} < 32'(Entries);
  endfunction

  assign cfg_ready_o   = (state_q == S_IDLE);
  assign s_axis_tready = (state_q == S_IDLE) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = od_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      shift_q <= 5'd9;
      lba_q   <= '0;
      count_q <= 17'd65536;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CfgShift: shift_q <= cfg_data_i[4:0];
          CfgLba:   lba_q   <= cfg_data_i;
          CfgCount: count_q <= cfg_data_i[16:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; cur_q <= cur_d; nxt_q <= nxt_d; n_q <= n_d; rem_q <= rem_d;
    len_q <= len_d; st_q <= st_d; resc_q <= resc_d;
    sect_q <= sect_d; ext_q <= ext_d; scan_q <= scan_d; sec_q <= sec_d;
    od_q <= od_d;
  end

  always_comb begin
    state_d = state_q;
    cmd_d = cmd_q; cur_d = cur_q; nxt_d = nxt_q; n_d = n_q; rem_d = rem_q;
    len_d = len_q; st_d = st_q; resc_d = resc_q;
    sect_d = sect_q; ext_d = ext_q; scan_d = scan_q; sec_d = sec_q;
    ov_d = ov_q; od_d = od_q;
    we = 1'b0; addr = AW'(cur_q); wdata = '0;
    if (ov_q && m_axis_tready) ov_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd_d = cmd_e'(cmd_in);
          cur_d = {12'd0, start_in};
          n_d = n_in; rem_d = rem_in;
          len_d = '0; st_d = ST_OK; resc_d = '0; sect_d = 1'b0; ext_d = 1'b0;
          scan_d = 28'd2;
          state_d = S_RD;
          case (cmd_e'(cmd_in))
            CMD_LOAD: begin
              resc_d = val_in; state_d = S_OUT;
              if (in_tab({12'd0, start_in})) begin
                we = 1'b1; addr = AW'(start_in); wdata = val_in;
              end
            end
            CMD_READ: begin
              if (!in_tab({12'd0, start_in})) begin
                resc_d = EndMark; state_d = S_OUT;
              end
            end
            CMD_ALLOC: state_d = S_SCAN_RD;
            CMD_LOC_RD, CMD_LOC_WR: begin
              if (!usable({12'd0, start_in}, lim)) begin
                st_d = ST_ENDED; state_d = S_OUT;
              end else if (n_in == 0) begin
                sect_d = 1'b1; state_d = S_SECT;
              end
            end
            CMD_TRUNC: begin
              if (!usable({12'd0, start_in}, lim)) begin
                if (n_in != 0 || rem_in != 0) st_d = ST_ENDED;
                state_d = S_OUT;
              end else if (n_in == 0 && rem_in == 0) begin
                nxt_d = {12'd0, start_in}; state_d = S_FREE_ACT;
              end else begin
                n_d = n_in + ((rem_in != 0) ? 32'd1 : 32'd0) - 32'd1;
              end
            end
            CMD_LENGTH: begin
              if (!usable({12'd0, start_in}, lim)) state_d = S_OUT;
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_RD: state_d = S_RDW;
      S_RDW: state_d = S_ACT;
      S_ACT: begin
        state_d = S_RD;
        case (cmd_q)
          CMD_READ: begin resc_d = rdata; state_d = S_OUT; end
          CMD_LOC_RD: begin
            cur_d = rdata;
            if (!usable(rdata, lim)) begin
              st_d = ST_ENDED; state_d = S_OUT;
            end else begin
              n_d = n_q - 32'd1;
              if (n_q == 32'd1) begin sect_d = 1'b1; state_d = S_SECT; end
            end
          end
          CMD_LOC_WR: begin
            if (rdata >= EndMin) begin
              ext_d = 1'b1; scan_d = 28'd2; state_d = S_SCAN_RD;
            end else if (!usable(rdata, lim)) begin
              st_d = ST_ENDED; state_d = S_OUT;
            end else begin
              cur_d = rdata; n_d = n_q - 32'd1;
              if (n_q == 32'd1) begin sect_d = 1'b1; state_d = S_SECT; end
            end
          end
          CMD_TRUNC: begin
            if (n_q == 0) begin
              we = 1'b1; addr = AW'(cur_q); wdata = EndMark;
              resc_d = cur_q; nxt_d = rdata; state_d = S_FREE_ACT;
            end else begin
              cur_d = rdata; n_d = n_q - 32'd1;
              if (!usable(rdata, lim)) begin st_d = ST_ENDED; state_d = S_OUT; end
            end
          end
          CMD_LENGTH: begin
            len_d = len_q + 17'd1;
            cur_d = rdata;
            if (!usable(rdata, lim) || (32'(len_q) + 32'd1 >= 32'(lim)))
              state_d = S_OUT;
          end
          default: state_d = S_OUT;
        endcase
      end
      S_SCAN_RD: begin
        addr = AW'(scan_q);
        if ({4'd0, scan_q} >= 32'(lim)) begin
          st_d = ST_NOFREE; state_d = S_OUT;
        end else state_d = S_SCAN_W;
      end
      S_SCAN_W: begin addr = AW'(scan_q); state_d = S_SCAN_ACT; end
      S_SCAN_ACT: begin
        if (rdata == 28'd0) begin
          we = 1'b1; addr = AW'(scan_q); wdata = EndMark;
          if (ext_q) begin
            nxt_d = scan_q; state_d = S_FREE_W; // link cur -> new next cycle
          end else begin
            resc_d = scan_q; cur_d = scan_q; rem_d = '0; sect_d = 1'b1;
            state_d = S_SECT;
          end
        end else begin
          scan_d = scan_q + 28'd1; state_d = S_SCAN_RD;
        end
      end
      S_FREE_RD: begin addr = AW'(nxt_q); state_d = S_FREE_W; end
      S_FREE_W: begin
        if (cmd_q == CMD_LOC_WR) begin
          we = 1'b1; addr = AW'(cur_q); wdata = nxt_q;
          cur_d = nxt_q; n_d = n_q - 32'd1; ext_d = 1'b0;
          if (n_q == 32'd1) begin sect_d = 1'b1; state_d = S_SECT; end
          else state_d = S_RD;
        end else begin
          addr = AW'(nxt_q);
          state_d = S_FREE_ACT;
          cur_d = nxt_q;
          sect_d = 1'b0;
          ext_d = 1'b1;
        end
      end
      S_FREE_ACT: begin
        if (ext_q) begin
          we = 1'b1; addr = AW'(cur_q); wdata = '0;
          nxt_d = rdata; ext_d = 1'b0;
        end else if (usable(nxt_q, lim)) begin
          addr = AW'(nxt_q); state_d = S_FREE_W;
        end else state_d = S_OUT;
      end
      S_SECT: begin
        sec_d = 40'(lba_q) + (40'(cur_q - 28'd2) << (sh - 5'd9)) + 40'(rem_q >> 9);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_d) begin
          ov_d = 1'b1;
          od_d = {1'b0, st_q, len_q, (sect_q && st_q == ST_OK) ? sec_q : 40'd0,
                  (cmd_q == CMD_LOC_RD || cmd_q == CMD_LOC_WR || cmd_q == CMD_ALLOC)
                    ? ((st_q == ST_OK) ? cur_q : 28'd0) : resc_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// File: bench/tb_fat_cluster_chain_engine_unit.sv
// Testbench for fat_cluster_chain_engine_unit: drives command beats and config writes,
// predicts every result with a behavioral copy of the allocation table and checks it.
// Depends on fcce_pkg and the engine RTL.
`timescale 1ns / 1ps
module tb_fat_cluster_chain_engine_unit;
  import fcce_pkg::*;

  localparam int Entries   = 65536;
  localparam int MaxVisits = 3000;
  localparam int WdogLimit = 200000;

  typedef struct packed {
    cmd_e        op;
    logic [15:0] start;
    logic [31:0] offset;
    logic [27:0] value;
  } chain_cmd_t;

  // first member lands in the highest bits
  typedef struct packed {
    status_e     status;
    logic [16:0] length;
    logic [39:0] sector;
    logic [27:0] cluster;
  } chain_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  fat_cluster_chain_engine_unit dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the table and registers
  logic [27:0] fat_mem [Entries];
  bit          written [Entries];
  logic [4:0]  shift_reg = 5'd9;
  logic [31:0] lba_reg = '0;
  logic [16:0] count_reg = 17'd65536;

  int          undo_idx[$];
  logic [27:0] undo_val[$];
  bit          undo_wr[$];
  bit          probe_bad;
  int          visits;

  chain_result_t pending_results[$];
  int  errors = 0;
  bit  idle_en = 1'b1;
  int  quiet_cycles = 0;

  function automatic int table_limit();
    return (count_reg > 17'd65536) ? Entries : int'(count_reg);
  endfunction

  function automatic bit usable(logic [27:0] c);
    return c >= 28'd2 && c < table_limit();
  endfunction

  function automatic int eff_shift();
    if (shift_reg < 5'd9) return 9;
    if (shift_reg > 5'd16) return 16;
    return int'(shift_reg);
  endfunction

  function automatic logic [27:0] fetch(logic [27:0] c);
    visits++;
    if (visits > MaxVisits || !written[c[15:0]]) probe_bad = 1'b1;
    return fat_mem[c[15:0]];
  endfunction

  function automatic void store(logic [27:0] c, logic [27:0] v);
    undo_idx.push_back(int'(c[15:0]));
    undo_val.push_back(fat_mem[c[15:0]]);
    undo_wr.push_back(written[c[15:0]]);
    fat_mem[c[15:0]] = v;
    written[c[15:0]] = 1'b1;
  endfunction

  function automatic logic [39:0] sector_of(logic [27:0] c, logic [31:0] rem);
    logic [63:0] s;
    s = 64'(lba_reg) + (64'(32'(c) - 32'd2) << (eff_shift() - 9)) + 64'(rem / 512);
    return s[39:0];
  endfunction

  function automatic bit grab_free(output logic [27:0] got);
    int l;
    l = table_limit();
    got = '0;
    for (int i = 2; i < l && !probe_bad; i++) begin
      if (fetch(28'(i)) == 28'd0 && !probe_bad) begin
        store(28'(i), EndMark);
        got = 28'(i);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // runs one command on the shadow; flags commands that would touch unwritten entries or exceed MaxVisits reads
  function automatic bit predict_chain(chain_cmd_t it, output chain_result_t r);
    int sh;
    logic [31:0] n, rem, keep, len;
    logic [27:0] cur, nxt, t;
    sh = eff_shift();
    n = it.offset >> sh;
    rem = it.offset & ((32'd1 << sh) - 1);
    r = '0;
    r.status = ST_OK;
    probe_bad = 1'b0;
    visits = 0;
    len = 0;
    cur = 28'(it.start);
    case (it.op)
      CMD_LOAD: begin
        store(cur, it.value);
        r.cluster = it.value;
      end
      CMD_READ: r.cluster = fetch(cur);
      CMD_ALLOC: begin
        if (grab_free(cur)) begin
          r.cluster = cur;
          r.sector = sector_of(cur, 0);
        end else r.status = ST_NOFREE;
      end
      CMD_LOC_RD: begin
        if (!usable(cur)) r.status = ST_ENDED;
        for (int i = 0; i < n && r.status == ST_OK && !probe_bad; i++) begin
          cur = fetch(cur);
          if (!usable(cur)) r.status = ST_ENDED;
        end
        if (r.status == ST_OK) begin
          r.cluster = cur;
          r.sector = sector_of(cur, rem);
        end
      end
      CMD_LOC_WR: begin
        if (!usable(cur)) r.status = ST_ENDED;
        for (int i = 0; i < n && r.status == ST_OK && !probe_bad; i++) begin
          nxt = fetch(cur);
          if (nxt >= EndMin) begin
            if (!grab_free(nxt)) r.status = ST_NOFREE;
            else store(cur, nxt);
          end else if (!usable(nxt)) r.status = ST_ENDED;
          if (r.status == ST_OK) cur = nxt;
        end
        if (r.status == ST_OK) begin
          r.cluster = cur;
          r.sector = sector_of(cur, rem);
        end
      end
      CMD_TRUNC: begin
        keep = n + ((rem != 0) ? 1 : 0);
        nxt = '0;
        if (!usable(cur)) begin
          if (keep != 0) r.status = ST_ENDED;
        end else begin
          if (keep == 0) nxt = cur;
          else begin
            for (int i = 1; i < keep && r.status == ST_OK && !probe_bad; i++) begin
              cur = fetch(cur);
              if (!usable(cur)) r.status = ST_ENDED;
            end
            if (r.status == ST_OK) begin
              nxt = fetch(cur);
              store(cur, EndMark);
              r.cluster = cur;
            end
          end
          if (r.status == ST_OK) begin
            while (usable(nxt) && !probe_bad) begin
              t = fetch(nxt);
              store(nxt, 28'd0);
              nxt = t;
            end
          end
        end
      end
      CMD_LENGTH: begin
        while (usable(cur) && len < table_limit() && !probe_bad) begin
          len++;
          cur = fetch(cur);
        end
        r.length = len[16:0];
      end
      default: ;
    endcase
    if (probe_bad) begin
      while (undo_idx.size() > 0) begin
        fat_mem[undo_idx[$]] = undo_val[$];
        written[undo_idx[$]] = undo_wr[$];
        void'(undo_idx.pop_back());
        void'(undo_val.pop_back());
        void'(undo_wr.pop_back());
      end
      return 1'b0;
    end
    undo_idx.delete();
    undo_val.delete();
    undo_wr.delete();
    return 1'b1;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_cmd(input chain_cmd_t it, output bit taken);
    chain_result_t r;
    taken = predict_chain(it, r);
    if (!taken) return;
    pending_results.push_back(r);
    if (idle_en) begin
      while ($urandom_range(99) < 38) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tdata = {1'b0, it.value, it.offset, it.start, it.op};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic send_now(cmd_e op, logic [15:0] start, logic [31:0] off, logic [27:0] val);
    bit taken;
    chain_cmd_t it;
    it = '{op: op, start: start, offset: off, value: val};
    send_cmd(it, taken);
  endtask

  task automatic drain();
    while (pending_results.size() > 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    drain();
    cfg_index_i = idx;
    cfg_data_i = data;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    case (idx)
      CfgShift: shift_reg = data[4:0];
      CfgLba:   lba_reg = data;
      CfgCount: count_reg = data[16:0];
      default: ;
    endcase
  endtask

  function automatic logic [27:0] rand_value();
    logic [27:0] v;
    case ($urandom_range(5))
      0, 1: v = 28'd0;
      2:    v = 28'($urandom_range(0, 129));
      3:    v = EndMark;
      4:    v = EndMin + 28'($urandom_range(0, 7));
      default: begin
        v = 28'($urandom);
        v[27:17] = v[27:17] | 11'd1;
      end
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rand_offset();
    logic [31:0] rem;
    int sh;
    sh = eff_shift();
    rem = $urandom & ((32'd1 << sh) - 1);
    case ($urandom_range(4))
      0:    return $urandom;
      1:    return 32'($urandom_range(0, 5)) << sh;
      default: return (32'($urandom_range(0, 5)) << sh) + rem;
    endcase
  endfunction

  function automatic chain_cmd_t rand_cmd();
    chain_cmd_t it;
    int pick;
    pick = $urandom_range(99);
    it.start = 16'($urandom_range(0, 129));
    it.offset = rand_offset();
    it.value = rand_value();
    if (pick < 18) it.op = CMD_LOAD;
    else if (pick < 26) it.op = CMD_READ;
    else if (pick < 38) it.op = CMD_ALLOC;
    else if (pick < 52) it.op = CMD_LOC_RD;
    else if (pick < 68) it.op = CMD_LOC_WR;
    else if (pick < 82) it.op = CMD_TRUNC;
    else if (pick < 96) it.op = CMD_LENGTH;
    else it.op = CMD_UNUSED;
    if (it.op inside {CMD_LOAD, CMD_READ} && $urandom_range(3) == 0) begin
      it.start = 16'($urandom);
      it.offset = $urandom;
    end
    return it;
  endfunction

  task automatic run_random(int items, bit pause_mid);
    int done;
    bit taken;
    done = 0;
    while (done < items) begin
      send_cmd(rand_cmd(), taken);
      if (taken) done++;
      if (pause_mid && done == items / 2) begin
        while (pending_results.size() > 0) @(negedge clk_i);
        pause_mid = 1'b0;
      end
    end
  endtask

  task automatic test_table_init();
    write_reg(CfgCount, 32'd128);
    write_reg(CfgShift, 32'd9);
    write_reg(CfgLba, 32'h100);
    for (int i = 0; i < 128; i++) send_now(CMD_LOAD, 16'(i), $urandom, 28'd0);
  endtask

  task automatic test_directed();
    send_now(CMD_LOAD, 16'd5, 32'hFFFF_FFFF, EndMark);
    send_now(CMD_READ, 16'd5, 32'd0, 28'd0);
    send_now(CMD_LOAD, 16'hFFFF, 32'd0, 28'h0ABCDEF);
    send_now(CMD_READ, 16'hFFFF, 32'd0, 28'd0);
    send_now(CMD_ALLOC, 16'd0, 32'd0, 28'd0);
    send_now(CMD_ALLOC, 16'd0, 32'd0, 28'd0);
    send_now(CMD_LOC_WR, 16'd2, 32'd1636, 28'd0);
    send_now(CMD_LOC_RD, 16'd2, 32'd1000, 28'd0);
    send_now(CMD_LOC_RD, 16'd2, 32'd4000, 28'd0);
    send_now(CMD_LENGTH, 16'd2, 32'd0, 28'd0);
    send_now(CMD_TRUNC, 16'd2, 32'd600, 28'd0);
    send_now(CMD_TRUNC, 16'd2, 32'd0, 28'd0);
    send_now(CMD_LENGTH, 16'd2, 32'd0, 28'd0);
    send_now(CMD_LOC_RD, 16'd0, 32'd0, 28'd0);
    send_now(CMD_LOC_WR, 16'd1, 32'd0, 28'd0);
    send_now(CMD_TRUNC, 16'd0, 32'd0, 28'd0);
    send_now(CMD_TRUNC, 16'd1, 32'd5, 28'd0);
    send_now(CMD_LENGTH, 16'd0, 32'd0, 28'd0);
    send_now(CMD_LOAD, 16'd10, 32'd0, 28'd1);
    send_now(CMD_LOAD, 16'd9, 32'd0, 28'd10);
    send_now(CMD_LOC_WR, 16'd9, 32'd4096, 28'd0);
    send_now(CMD_LOAD, 16'd11, 32'd0, EndMin);
    send_now(CMD_LOC_WR, 16'd11, 32'd700, 28'd0);
    send_now(CMD_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 28'h0FFFFFF);
  endtask

  task automatic test_no_free();
    write_reg(CfgCount, 32'd4);
    repeat (3) send_now(CMD_ALLOC, 16'd0, 32'd0, 28'd0);
    send_now(CMD_LOAD, 16'd3, 32'd0, 28'd0);
    send_now(CMD_LOAD, 16'd2, 32'd0, EndMark);
    send_now(CMD_LOC_WR, 16'd2, 32'd5000, 28'd0);
    write_reg(CfgCount, 32'd2);
    send_now(CMD_ALLOC, 16'd0, 32'd0, 28'd0);
    send_now(CMD_LENGTH, 16'd2, 32'd0, 28'd0);
  endtask

  task automatic test_shift_clamp();
    write_reg(CfgCount, 32'd128);
    write_reg(CfgShift, 32'd3);
    send_now(CMD_LOC_WR, 16'd2, 32'd2000, 28'd0);
    write_reg(CfgShift, 32'd20);
    send_now(CMD_LOC_RD, 16'd2, 32'd70000, 28'd0);
  endtask

  task automatic test_random_phases();
    write_reg(CfgShift, 32'd9);
    write_reg(CfgLba, 32'd0);
    run_random(60, 1'b1);
    write_reg(CfgShift, 32'd16);
    write_reg(CfgLba, 32'hFFFF_FFFF);
    write_reg(CfgCount, 32'd130);
    idle_en = 1'b0;
    run_random(40, 1'b0);
    idle_en = 1'b1;
    write_reg(CfgShift, 32'd31);
    write_reg(CfgLba, $urandom);
    write_reg(CfgCount, 32'd40);
    run_random(50, 1'b0);
    write_reg(CfgShift, 32'd0);
    write_reg(CfgCount, 32'd2);
    run_random(20, 1'b0);
    write_reg(CfgShift, 32'd12);
    write_reg(CfgLba, $urandom);
    write_reg(CfgCount, 32'd128);
    run_random(40, 1'b0);
  endtask

  task automatic test_full_count();
    write_reg(CfgCount, 32'd65536);
    run_random(15, 1'b0);
    write_reg(CfgCount, 32'h1FFFF);
    run_random(15, 1'b0);
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= !idle_en || ($urandom_range(99) >= 38);
  end

  always @(posedge clk_i) begin
    chain_result_t want;
    chain_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[86:0];
      if (pending_results.size() == 0) begin
        $error("unexpected result beat %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.cluster !== want.cluster) begin
          $error("cluster: expected %h actual %h", want.cluster, got.cluster);
          errors++;
        end
        if (got.sector !== want.sector) begin
          $error("sector_lba: expected %h actual %h", want.sector, got.sector);
          errors++;
        end
        if (got.length !== want.length) begin
          $error("chain_length: expected %0d actual %0d", want.length, got.length);
          errors++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, got.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_table_init();
    test_directed();
    test_no_free();
    test_shift_clamp();
    test_random_phases();
    test_full_count();
    while (pending_results.size() > 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
